>>> hdl/lpm_pkg.sv
`default_nettype none
package lpm_pkg;

  // default sizing
  localparam int MAX_FRAME_PIXELS_LOG2_DEF = 23;
  localparam int MAX_FRAMES_LOG2_DEF       = 20;

  // arithmetic constants
  localparam logic [15:0] PEAK_RESET      = 16'd65025;
  localparam int          TEN_LOG10_2_Q16 = 197283;
  localparam logic [15:0] HUNDRED_DB_Q8   = 16'd25600;
  localparam logic [15:0] Q8_MAX          = 16'hFFFF;
  localparam int          MANT_W          = 31;
  localparam int          FRAC_BITS       = 16;
  localparam int          QUEUE_DEPTH     = 2;

  typedef struct packed {
    logic [7:0] ref_pixel;
    logic [7:0] test_pixel;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic [15:0] frame_psnr;
    logic [15:0] mean_psnr;
    logic [19:0] frames_done;
    logic        exact_match;
  } out_t;

  typedef enum logic [1:0] {
    LG_IDLE,
    LG_NORM,
    LG_SQR
  } log_state_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_PROD,
    BK_LOGA_GO,
    BK_LOGA_WAIT,
    BK_LOGB_GO,
    BK_LOGB_WAIT,
    BK_SCALE,
    BK_ACC,
    BK_DIVINIT,
    BK_DIV,
    BK_EMIT
  } back_state_t;

endpackage
`default_nettype wire

>>> hdl/lpm_fifo.sv
`default_nettype none
module lpm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lpm_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  // pointer wrap and fill count
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (do_pop)  rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
  end
endmodule
`default_nettype wire

>>> hdl/lpm_front.sv
`default_nettype none
module lpm_front #(
  parameter int MAX_FRAME_PIXELS_LOG2 = lpm_pkg::MAX_FRAME_PIXELS_LOG2_DEF,
  localparam int EW = 16 + MAX_FRAME_PIXELS_LOG2,
  localparam int PW = MAX_FRAME_PIXELS_LOG2 + 1,
  localparam int JW = 1 + EW + PW + 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_push,
  input  wire lpm_pkg::in_t in_data,
  output logic              in_full,
  input  wire logic         cfg_we,
  input  wire logic [15:0]  cfg_data,
  output logic              job_push,
  output logic [JW-1:0]     job_data,
  input  wire logic         job_full
);
  logic [15:0]   peak_r;
  logic [EW-1:0] err_r, err_nxt;
  logic [PW-1:0] pc_r, pc_nxt;
  logic [7:0]    diff;
  logic [15:0]   sq;
  logic          accept;
  logic [15:0]   peak_eff;

  assign in_full  = job_full;
  assign accept   = in_push && !job_full;
  assign peak_eff = (peak_r == '0) ? 16'd1 : peak_r;

  // absolute difference, squared
  always_comb begin
    diff = (in_data.ref_pixel > in_data.test_pixel) ?
           in_data.ref_pixel - in_data.test_pixel :
           in_data.test_pixel - in_data.ref_pixel;
    sq = 16'(diff * diff);
  end

  // accumulate until the pixel counter saturates
  always_comb begin
    err_nxt = err_r;
    pc_nxt  = pc_r;
    if (!pc_r[PW-1]) begin
      err_nxt = err_r + EW'(sq);
      pc_nxt  = pc_r + 1'b1;
    end
  end

  // frame close request to the back end
  assign job_push = accept && in_data.frame_end;
  assign job_data = {(err_nxt == '0), err_nxt, pc_nxt, peak_eff};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r <= lpm_pkg::PEAK_RESET;
      err_r  <= '0;
      pc_r   <= '0;
    end else begin
      if (cfg_we) peak_r <= cfg_data;
      if (accept) begin
        if (in_data.frame_end) begin
          err_r <= '0;
          pc_r  <= '0;
        end else begin
          err_r <= err_nxt;
          pc_r  <= pc_nxt;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> hdl/lpm_log2.sv
`default_nettype none
module lpm_log2 #(
  parameter int XW = 40,
  localparam int EBW  = $clog2(XW),
  localparam int LOGW = EBW + lpm_pkg::FRAC_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [XW-1:0] x,
  output logic               done,
  output logic [LOGW-1:0]    logv
);
  localparam int MW = lpm_pkg::MANT_W;

  lpm_pkg::log_state_t st_r, st_nxt;
  logic [XW-1:0]  x_r;
  logic [EBW-1:0] e_r;
  logic [MW-1:0]  m_r;
  logic [15:0]    frac_r;
  logic [3:0]     it_r;
  logic           done_r;
  logic [2*MW-1:0] prod;
  logic [MW:0]    sqv;
  logic           last_it;

  assign prod    = (2*MW)'(m_r) * (2*MW)'(m_r);
  assign sqv     = prod[2*MW-1:MW-1];
  assign last_it = (it_r == 4'hF);
  assign done    = done_r;
  assign logv    = {e_r, frac_r};

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      lpm_pkg::LG_IDLE: if (start) st_nxt = lpm_pkg::LG_NORM;
      lpm_pkg::LG_NORM: if (x_r[XW-1]) st_nxt = lpm_pkg::LG_SQR;
      lpm_pkg::LG_SQR:  if (last_it) st_nxt = lpm_pkg::LG_IDLE;
      default:          st_nxt = lpm_pkg::LG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= lpm_pkg::LG_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == lpm_pkg::LG_SQR) && last_it;
    end
  end

  // normalize one bit a cycle, then one squaring per fraction bit
  always_ff @(posedge clk) begin
    unique case (st_r)
      lpm_pkg::LG_IDLE: begin
        x_r  <= x;
        e_r  <= EBW'(XW - 1);
        it_r <= '0;
      end
      lpm_pkg::LG_NORM: begin
        if (x_r[XW-1]) begin
          m_r <= x_r[XW-1 -: MW];
        end else begin
          x_r <= {x_r[XW-2:0], 1'b0};
          e_r <= e_r - 1'b1;
        end
      end
      lpm_pkg::LG_SQR: begin
        frac_r <= {frac_r[14:0], sqv[MW]};
        m_r    <= sqv[MW] ? sqv[MW:1] : sqv[MW-1:0];
        it_r   <= it_r + 1'b1;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

>>> hdl/lpm_back.sv
`default_nettype none
module lpm_back #(
  parameter int MAX_FRAME_PIXELS_LOG2 = lpm_pkg::MAX_FRAME_PIXELS_LOG2_DEF,
  parameter int MAX_FRAMES_LOG2       = lpm_pkg::MAX_FRAMES_LOG2_DEF,
  localparam int EW = 16 + MAX_FRAME_PIXELS_LOG2,
  localparam int PW = MAX_FRAME_PIXELS_LOG2 + 1,
  localparam int JW = 1 + EW + PW + 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [JW-1:0] job_data,
  input  wire logic          job_empty,
  output logic               job_pop,
  output lpm_pkg::out_t      res_data,
  output logic               res_push,
  input  wire logic          res_full
);
  localparam int F    = MAX_FRAMES_LOG2;
  localparam int XW   = (EW + 1 > lpm_pkg::MANT_W) ? EW + 1 : lpm_pkg::MANT_W;
  localparam int LOGW = $clog2(XW) + lpm_pkg::FRAC_BITS;
  localparam int VW   = LOGW + 20;
  localparam int RW   = VW - 23;
  localparam int TW   = 16 + F;
  localparam int DW   = TW + 1;
  localparam int CW   = $clog2(DW + 1);
  localparam int FW   = (F > 20) ? F : 20;

  lpm_pkg::back_state_t st_r, st_nxt;

  logic            exact_r;
  logic [EW-1:0]   err_r;
  logic [PW-1:0]   pc_r;
  logic [15:0]     peak_r;
  logic [XW-1:0]   pp_r;
  logic [LOGW-1:0] la_r, lb_r;
  logic signed [VW-1:0] v_r;
  logic [15:0]     psnr_r;
  logic [TW-1:0]   total_r;
  logic [F-1:0]    fc_r;
  logic [DW-1:0]   dq_r;
  logic [F-1:0]    rem_r;
  logic [CW-1:0]   cnt_r;

  logic            log_start, log_done;
  logic [XW-1:0]   log_x;
  logic [LOGW-1:0] log_v;
  logic signed [LOGW:0] d_s;
  logic signed [VW-1:0] v_nxt;
  logic [RW-1:0]   r_sum;
  logic [15:0]     psnr_nxt;
  logic [F:0]      rem_sh;
  logic            q_bit;
  logic [FW-1:0]   fc_ext;

  // shared log2 unit
  assign log_x = exact_r ? XW'(peak_r) : pp_r;

  lpm_log2 #(.XW(XW)) u_log2 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (log_start),
    .x     (log_x),
    .done  (log_done),
    .logv  (log_v)
  );

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      lpm_pkg::BK_IDLE:      if (!job_empty) st_nxt = lpm_pkg::BK_PROD;
      lpm_pkg::BK_PROD:      st_nxt = lpm_pkg::BK_LOGA_GO;
      lpm_pkg::BK_LOGA_GO:   st_nxt = lpm_pkg::BK_LOGA_WAIT;
      lpm_pkg::BK_LOGA_WAIT:
        if (log_done) st_nxt = exact_r ? lpm_pkg::BK_SCALE : lpm_pkg::BK_LOGB_GO;
      lpm_pkg::BK_LOGB_GO:   st_nxt = lpm_pkg::BK_LOGB_WAIT;
      lpm_pkg::BK_LOGB_WAIT: if (log_done) st_nxt = lpm_pkg::BK_SCALE;
      lpm_pkg::BK_SCALE:     st_nxt = lpm_pkg::BK_ACC;
      lpm_pkg::BK_ACC:       st_nxt = lpm_pkg::BK_DIVINIT;
      lpm_pkg::BK_DIVINIT:   st_nxt = lpm_pkg::BK_DIV;
      lpm_pkg::BK_DIV:       if (cnt_r == CW'(DW - 1)) st_nxt = lpm_pkg::BK_EMIT;
      lpm_pkg::BK_EMIT:      if (!res_full) st_nxt = lpm_pkg::BK_IDLE;
      default:               st_nxt = lpm_pkg::BK_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    job_pop   = (st_r == lpm_pkg::BK_IDLE) && !job_empty;
    log_start = (st_r == lpm_pkg::BK_LOGA_GO) || (st_r == lpm_pkg::BK_LOGB_GO);
    res_push  = (st_r == lpm_pkg::BK_EMIT) && !res_full;
  end

  // dB scaling and clamp
  always_comb begin
    d_s   = exact_r ? $signed({1'b0, la_r}) : $signed({1'b0, la_r}) - $signed({1'b0, lb_r});
    v_nxt = VW'(d_s) * VW'(19'sd197283) + VW'(25'sh0800000);
    r_sum = RW'(v_r[VW-1:24]) + (exact_r ? RW'(lpm_pkg::HUNDRED_DB_Q8) : RW'(0));
    if (v_r[VW-1])                          psnr_nxt = '0;
    else if (r_sum > RW'(lpm_pkg::Q8_MAX))  psnr_nxt = lpm_pkg::Q8_MAX;
    else                                    psnr_nxt = r_sum[15:0];
  end

  // restoring divider step
  always_comb begin
    rem_sh = {rem_r, dq_r[DW-1]};
    q_bit  = (rem_sh >= {1'b0, fc_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= lpm_pkg::BK_IDLE;
      total_r <= '0;
      fc_r    <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == lpm_pkg::BK_ACC && !(&fc_r)) begin
        total_r <= total_r + TW'(psnr_nxt);
        fc_r    <= fc_r + 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      lpm_pkg::BK_IDLE: {exact_r, err_r, pc_r, peak_r} <= job_data;
      lpm_pkg::BK_PROD: pp_r <= XW'(peak_r * pc_r);
      lpm_pkg::BK_LOGA_WAIT: begin
        la_r <= log_v;
        pp_r <= XW'(err_r);
      end
      lpm_pkg::BK_LOGB_WAIT: lb_r <= log_v;
      lpm_pkg::BK_SCALE: v_r <= v_nxt;
      lpm_pkg::BK_ACC:   psnr_r <= psnr_nxt;
      lpm_pkg::BK_DIVINIT: begin
        dq_r  <= DW'(total_r) + DW'(fc_r >> 1);
        rem_r <= '0;
        cnt_r <= '0;
      end
      lpm_pkg::BK_DIV: begin
        rem_r <= q_bit ? F'(rem_sh - {1'b0, fc_r}) : rem_sh[F-1:0];
        dq_r  <= {dq_r[DW-2:0], q_bit};
        cnt_r <= cnt_r + 1'b1;
      end
      default: ;
    endcase
  end

  // result assembly
  assign fc_ext = FW'(fc_r);
  always_comb begin
    res_data.frame_psnr  = psnr_r;
    res_data.mean_psnr   = (|dq_r[DW-1:16]) ? lpm_pkg::Q8_MAX : dq_r[15:0];
    res_data.frames_done = fc_ext[19:0];
    res_data.exact_match = exact_r;
  end
endmodule
`default_nettype wire

>>> hdl/luma_psnr_meter.sv
`default_nettype none
// Luma PSNR meter.
// Input queue side: present a pixel pair on in_data and raise in_push; it is
// taken on a clock edge with in_push high and in_full low. Set frame_end on
// the last pair of each frame. Pixels are taken one per clock; in_full rises
// only while the frame-close queue (two deep) is full.
// Result queue side: one result per frame, held on out_data while out_empty is
// low, taken on an edge with out_pop high. A stalled receiver fills the
// two-entry result queue, then the back end waits, then the close queue
// fills and in_full rises; nothing is lost.
// The result of the frame_end pair is computed by the back end with the one-bit
// normalize shifter, the 16-step squaring log2 unit (log operand width XW =
// max(31, 17 + MAX_FRAME_PIXELS_LOG2)) and the bit-serial mean divider.
// Exact frames skip the second log and its start state. The back end closes
// one frame at a time; later frame closes wait in the close queue.
// cfg_we/cfg_data write peak_squared (reset 65025). Reset empties both
// queues and clears all totals.
module luma_psnr_meter #(
  parameter int MAX_FRAME_PIXELS_LOG2 = lpm_pkg::MAX_FRAME_PIXELS_LOG2_DEF,
  parameter int MAX_FRAMES_LOG2       = lpm_pkg::MAX_FRAMES_LOG2_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  input  wire lpm_pkg::in_t  in_data,
  output logic               in_full,
  output logic               out_empty,
  input  wire logic          out_pop,
  output lpm_pkg::out_t      out_data,
  input  wire logic          cfg_we,
  input  wire logic [15:0]   cfg_data
);
  localparam int JW = 1 + (16 + MAX_FRAME_PIXELS_LOG2) + (MAX_FRAME_PIXELS_LOG2 + 1) + 16;
  localparam int OW = $bits(lpm_pkg::out_t);

  logic          job_push, job_full, job_pop, job_empty;
  logic [JW-1:0] job_wdata, job_rdata;
  logic          res_push, res_full;
  lpm_pkg::out_t res_data;
  logic [OW-1:0] res_rdata;

  lpm_front #(.MAX_FRAME_PIXELS_LOG2(MAX_FRAME_PIXELS_LOG2)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .job_push (job_push),
    .job_data (job_wdata),
    .job_full (job_full)
  );

  lpm_fifo #(.WIDTH(JW), .DEPTH(lpm_pkg::QUEUE_DEPTH)) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_wdata),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_rdata),
    .empty (job_empty)
  );

  lpm_back #(
    .MAX_FRAME_PIXELS_LOG2(MAX_FRAME_PIXELS_LOG2),
    .MAX_FRAMES_LOG2      (MAX_FRAMES_LOG2)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_data  (job_rdata),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .res_data  (res_data),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  lpm_fifo #(.WIDTH(OW), .DEPTH(lpm_pkg::QUEUE_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign out_data = res_rdata;
endmodule
`default_nettype wire

>>> hdl/lpm_checker.sv
`default_nettype none
module lpm_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_full,
  input wire logic          out_empty,
  input wire logic          out_pop,
  input wire lpm_pkg::out_t out_data
);
  // reset drains both queues
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // a waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> $stable(out_data))
    else $error("result changed while stalled");

  // every result counts at least one frame
  a_frames: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.frames_done != 20'd0))
    else $error("result with zero frame count");

  // a clamped zero-error frame is at least 100 dB
  a_exact: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.exact_match) |-> (out_data.frame_psnr >= 16'd25600))
    else $error("exact frame below 100 dB");
endmodule

bind luma_psnr_meter lpm_checker u_lpm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);
`default_nettype wire

>>> dv/luma_psnr_checker.sv
`timescale 1ns / 1ps
module luma_psnr_checker (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  input  wire logic          in_full,
  input  wire lpm_pkg::in_t  in_data,
  input  wire logic          out_pop,
  input  wire logic          out_empty,
  input  wire lpm_pkg::out_t out_data,
  input  wire logic          cfg_we,
  input  wire logic [15:0]   cfg_data,
  output int                 errors,
  output int                 pending
);
  localparam int PIX_LOG2 = lpm_pkg::MAX_FRAME_PIXELS_LOG2_DEF;
  localparam int FRM_LOG2 = lpm_pkg::MAX_FRAMES_LOG2_DEF;

  // predictor state
  logic [15:0]   peak_sq;
  logic [63:0]   err_acc;
  logic [63:0]   pix_cnt;
  logic [63:0]   psnr_sum;
  logic [63:0]   frm_cnt;
  lpm_pkg::out_t frame_reports[$];

  assign pending = frame_reports.size();

  // log2 in Q.16 by repeated squaring of the normalized mantissa
  function automatic longint log2_q16(logic [63:0] x);
    int          e;
    logic [63:0] m;
    longint      frac;
    e = 63;
    frac = 0;
    while (e > 0 && x[e] == 1'b0) e--;
    if (e >= 30) m = x >> (e - 30);
    else m = x << (30 - e);
    for (int i = 0; i < lpm_pkg::FRAC_BITS; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return longint'(e) * 65536 + frac;
  endfunction

  // dB conversion with clamp at zero and at full scale
  function automatic logic [15:0] to_db_q8(longint lg, longint offset);
    longint v;
    longint r;
    v = lg * lpm_pkg::TEN_LOG10_2_Q16 + (longint'(1) << 23);
    if (v < 0) return 16'd0;
    r = (v >>> 24) + offset;
    return (r > 65535) ? 16'hFFFF : r[15:0];
  endfunction

  function automatic lpm_pkg::out_t close_frame();
    lpm_pkg::out_t rpt;
    logic [63:0]   peak;
    logic [63:0]   mean;
    peak = (peak_sq == 16'd0) ? 64'd1 : 64'(peak_sq);
    rpt.exact_match = (err_acc == 0);
    if (err_acc == 0)
      rpt.frame_psnr = to_db_q8(log2_q16(peak), longint'(lpm_pkg::HUNDRED_DB_Q8));
    else
      rpt.frame_psnr = to_db_q8(log2_q16(peak * pix_cnt) - log2_q16(err_acc), 0);
    if (frm_cnt < (64'd1 << FRM_LOG2) - 1) begin
      psnr_sum = psnr_sum + 64'(rpt.frame_psnr);
      frm_cnt = frm_cnt + 1;
    end
    mean = (psnr_sum + frm_cnt / 2) / frm_cnt;
    rpt.mean_psnr = (mean > 64'hFFFF) ? 16'hFFFF : mean[15:0];
    rpt.frames_done = frm_cnt[19:0];
    return rpt;
  endfunction

  // track requests on all three ports
  always @(posedge clk) begin
    logic [63:0]   diff;
    lpm_pkg::out_t want;
    if (!rst_n) begin
      peak_sq <= lpm_pkg::PEAK_RESET;
      err_acc = 0;
      pix_cnt = 0;
      psnr_sum = 0;
      frm_cnt = 0;
      errors = 0;
      frame_reports.delete();
    end else begin
      if (in_push && !in_full) begin
        diff = (in_data.ref_pixel > in_data.test_pixel) ?
               64'(in_data.ref_pixel - in_data.test_pixel) :
               64'(in_data.test_pixel - in_data.ref_pixel);
        if (pix_cnt < (64'd1 << PIX_LOG2)) begin
          err_acc = err_acc + diff * diff;
          pix_cnt = pix_cnt + 1;
        end
        if (in_data.frame_end) begin
          frame_reports.push_back(close_frame());
          err_acc = 0;
          pix_cnt = 0;
        end
      end
      if (out_pop && !out_empty) begin
        if (frame_reports.size() == 0) begin
          $display("%0t: result with nothing expected: %p", $time, out_data);
          errors++;
        end else begin
          want = frame_reports.pop_front();
          if (want.frame_psnr !== out_data.frame_psnr) begin
            $display("%0t: frame_psnr expected %0d got %0d", $time,
                     want.frame_psnr, out_data.frame_psnr);
            errors++;
          end
          if (want.mean_psnr !== out_data.mean_psnr) begin
            $display("%0t: mean_psnr expected %0d got %0d", $time,
                     want.mean_psnr, out_data.mean_psnr);
            errors++;
          end
          if (want.frames_done !== out_data.frames_done) begin
            $display("%0t: frames_done expected %0d got %0d", $time,
                     want.frames_done, out_data.frames_done);
            errors++;
          end
          if (want.exact_match !== out_data.exact_match) begin
            $display("%0t: exact_match expected %0b got %0b", $time,
                     want.exact_match, out_data.exact_match);
            errors++;
          end
        end
      end
      if (cfg_we) peak_sq <= cfg_data;
    end
  end
endmodule

>>> dv/luma_psnr_meter_test.sv
`timescale 1ns / 1ps
module luma_psnr_meter_test;
  localparam int SETTLE_CYCLES = 300;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_push = 1'b0;
  lpm_pkg::in_t  in_data = '0;
  logic          in_full;
  logic          out_empty;
  logic          out_pop = 1'b0;
  lpm_pkg::out_t out_data;
  logic          cfg_we = 1'b0;
  logic [15:0]   cfg_data = '0;
  int            errors;
  int            pending;
  logic          calm = 1'b0;
  int            sent = 0;

  always #5 clk = ~clk;

  luma_psnr_meter dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_data(in_data), .in_full(in_full),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  luma_psnr_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_pop(out_pop), .out_empty(out_empty), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  // receiver stalls at random unless in a calm stretch
  always @(posedge clk) begin
    if (!rst_n) out_pop <= 1'b0;
    else out_pop <= calm || ($urandom_range(99) >= 19);
  end

  // one pixel request, then maybe a one-cycle gap
  task automatic push_pixel(logic [7:0] r, logic [7:0] t, logic last);
    in_data <= '{ref_pixel: r, test_pixel: t, frame_end: last};
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    sent++;
    if (!calm && $urandom_range(99) < 19) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
  endtask

  // wait for every frame report, then let the back end settle
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_peak(logic [15:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // frame with random content: exact, near, wide or extreme pixels
  task automatic random_frame(int len);
    int          flavor;
    logic [7:0]  r;
    logic [7:0]  t;
    flavor = $urandom_range(3);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(255);
      case (flavor)
        0: t = r;
        1: t = r + 8'($urandom_range(6)) - 8'd3;
        2: t = $urandom_range(255);
        default: begin
          r = $urandom_range(1) ? 8'hFF : 8'h00;
          t = $urandom_range(1) ? 8'hFF : 8'h00;
        end
      endcase
      push_pixel(r, t, i == len - 1);
    end
  endtask

  task automatic directed_frames();
    push_pixel(8'd0, 8'd0, 1'b1);
    push_pixel(8'd255, 8'd0, 1'b1);
    push_pixel(8'd0, 8'd255, 1'b1);
    push_pixel(8'd255, 8'd255, 1'b0);
    push_pixel(8'd17, 8'd16, 1'b0);
    push_pixel(8'd128, 8'd130, 1'b1);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes at reset peak, then each peak setting
    directed_frames();
    set_peak(16'd1);
    directed_frames();
    set_peak(16'd0);
    directed_frames();
    set_peak(16'd65535);
    directed_frames();

    // random frames, changing peak between phases
    while (sent < 1150) begin
      if (sent > 300 && sent < 500) calm <= 1'b1;
      else calm <= 1'b0;
      if ($urandom_range(99) < 2) begin
        case ($urandom_range(3))
          0: set_peak(16'd55225);
          1: set_peak(16'd65025);
          2: set_peak(16'd1);
          default: set_peak(16'($urandom_range(65535)));
        endcase
      end
      if ($urandom_range(99) == 0) random_frame($urandom_range(200, 100));
      else random_frame($urandom_range(12, 1));
    end
    calm <= 1'b0;
    drain();
    if (errors == 0) begin
      $display("luma_psnr_meter_test: PASS");
    end else begin
      $display("luma_psnr_meter_test: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("luma_psnr_meter_test: FAIL");
    $finish;
  end
endmodule
